// File: hw/rtl/rmsm_pkg.sv
// ----------------------------------------------------------------------------
// rmsm_pkg
// Shared widths, types and constants of the running statistics unit.
// ----------------------------------------------------------------------------
package rmsm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int SUM_BITS    = 32;
  localparam int SQ_BITS     = 48;
  localparam int Q8_BITS     = 24;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [COUNT_BITS-1:0]  count_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic        [SQ_BITS-1:0]     sq_sum_t;
  typedef logic signed [Q8_BITS-1:0]     mean_t;
  typedef logic        [Q8_BITS-1:0]     stdev_t;

  localparam count_t COUNT_MAX = '1;

  // accumulator state right after one transaction
  typedef struct packed {
    count_t  count;
    sum_t    sum;
    sq_sum_t sq_sum;
    sample_t lo;
    sample_t hi;
    logic    sat;
  } snapshot_t;

endpackage

// File: hw/rtl/rmsm_if.sv
// ----------------------------------------------------------------------------
// rmsm_in_if / rmsm_out_if
// Valid/ready channels carrying samples in and statistics out.
// ----------------------------------------------------------------------------
interface rmsm_in_if;
  import rmsm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    clear_first;

  modport source (output valid, output sample, output clear_first, input ready);
  modport sink   (input valid, input sample, input clear_first, output ready);
endinterface

interface rmsm_out_if;
  import rmsm_pkg::*;
  logic    valid;
  logic    ready;
  count_t  sample_count;
  mean_t   mean_q8;
  stdev_t  stdev_q8;
  sample_t lowest;
  sample_t highest;
  logic    saturated;

  modport source (output valid, output sample_count, output mean_q8, output stdev_q8,
                  output lowest, output highest, output saturated, input ready);
  modport sink   (input valid, input sample_count, input mean_q8, input stdev_q8,
                  input lowest, input highest, input saturated, output ready);
endinterface

// File: hw/rtl/running_mean_stdev_minmax_unit.sv
// ----------------------------------------------------------------------------
// running_mean_stdev_minmax_unit
// Running count, mean, sample standard deviation and extremes of a stream.
// ----------------------------------------------------------------------------
// Each sample returns one result once it reaches the back end, which loads it,
// forms the products and the variance numerator, runs the serial divider (the
// mean divide runs alongside it) and the square root, and then loads the output
// register once that register is free. Accumulators update on
// acceptance and a two-entry queue lets up to two further samples be taken
// while one is computed and a finished result waits at the output.
module running_mean_stdev_minmax_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmsm_in_if.sink    in_i,
  rmsm_out_if.source out_o
);
  import rmsm_pkg::*;

  logic      push, full, pop, qvalid;
  snapshot_t snap_in, snap_out;

  rmsm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .snap_o (snap_in),
    .full_i (full)
  );

  rmsm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (snap_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qvalid),
    .data_o  (snap_out)
  );

  rmsm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (qvalid),
    .snap_i  (snap_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// File: hw/rtl/rmsm_front.sv
// ----------------------------------------------------------------------------
// rmsm_front
// Accepts samples, updates count, sums and extremes, queues a snapshot.
// ----------------------------------------------------------------------------
module rmsm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  rmsm_in_if.sink             in_i,
  output logic                push_o,
  output rmsm_pkg::snapshot_t snap_o,
  input  logic                full_i
);
  import rmsm_pkg::*;

  count_t  tally_q, tally_d, t_base;
  sum_t    sum_q, sum_d, s_base;
  sq_sum_t sq_q, sq_d, q_base;
  sample_t lo_q, lo_d, l_base;
  sample_t hi_q, hi_d, h_base;
  logic    sat;
  logic signed [2*SAMPLE_BITS-1:0] sqr;
  sample_t d;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign d          = in_i.sample;
  assign sqr        = d * d;

  always_comb begin
    if (in_i.clear_first) begin
      t_base = '0; s_base = '0; q_base = '0; l_base = '0; h_base = '0;
    end else begin
      t_base = tally_q; s_base = sum_q; q_base = sq_q; l_base = lo_q; h_base = hi_q;
    end
    sat     = 1'b0;
    tally_d = t_base;
    sum_d   = s_base;
    sq_d    = q_base;
    lo_d    = l_base;
    hi_d    = h_base;
    if (t_base == COUNT_MAX) begin
      sat = 1'b1;
    end else begin
      tally_d = t_base + 1'b1;
      sum_d   = s_base + {{(SUM_BITS-SAMPLE_BITS){d[SAMPLE_BITS-1]}}, d};
      sq_d    = q_base + {{(SQ_BITS-2*SAMPLE_BITS){1'b0}}, sqr};
      if (t_base == '0) begin
        lo_d = d;
        hi_d = d;
      end else if (d < l_base) begin
        lo_d = d;
      end else if (d > h_base) begin
        hi_d = d;
      end
    end
  end

  assign snap_o = '{count: tally_d, sum: sum_d, sq_sum: sq_d, lo: lo_d, hi: hi_d, sat: sat};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
    end else if (push_o) begin
      tally_q <= tally_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

endmodule

// File: hw/rtl/rmsm_fifo.sv
// ----------------------------------------------------------------------------
// rmsm_fifo
// Two-entry snapshot queue between front and back.
// ----------------------------------------------------------------------------
module rmsm_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rmsm_pkg::snapshot_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output rmsm_pkg::snapshot_t data_o
);
  import rmsm_pkg::*;

  snapshot_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// File: hw/rtl/rmsm_back.sv
// ----------------------------------------------------------------------------
// rmsm_back
// Computes mean and standard deviation of one snapshot with serial divide
// and square root units, then holds the result in the output register.
// ----------------------------------------------------------------------------
module rmsm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  rmsm_pkg::snapshot_t snap_i,
  output logic                pop_o,
  rmsm_out_if.source          out_o
);
  import rmsm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUB  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]  st_q;
  snapshot_t   snap_q;
  logic        neg_q;
  logic [31:0] mag_q, den_q, drem_q;
  logic [63:0] prod_q, ssq_q, num;
  logic [47:0] dsh_q, dquo_q, sv_q;
  logic [5:0]  cnt_q;
  logic [15:0] mrem_q;
  logic [23:0] msh_q, mquo_q, sroot_q;
  logic [24:0] srem_q;
  logic [32:0] dtr;
  logic        dge;
  logic [16:0] mtr;
  logic        mge;
  logic [26:0] str, strial;
  logic        sge;
  logic        out_free;

  logic    ov_q;
  count_t  o_cnt_q;
  mean_t   o_mean_q;
  stdev_t  o_sd_q;
  sample_t o_lo_q, o_hi_q;
  logic    o_sat_q;

  assign pop_o    = (st_q == ST_IDLE) && valid_i;
  assign out_free = !ov_q || out_o.ready;
  assign num      = (prod_q >= ssq_q) ? prod_q - ssq_q : 64'd0;
  assign dtr      = {drem_q, dsh_q[47]};
  assign dge      = dtr >= {1'b0, den_q};
  assign mtr      = {mrem_q, msh_q[23]};
  assign mge      = mtr >= {1'b0, snap_q.count};
  assign str      = {srem_q, sv_q[47:46]};
  assign strial   = {1'b0, sroot_q, 2'b01};
  assign sge      = str >= strial;

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        snap_q <= snap_i;
        neg_q  <= snap_i.sum[SUM_BITS-1];
        mag_q  <= snap_i.sum[SUM_BITS-1] ? 32'(-snap_i.sum) : 32'(snap_i.sum);
      end
      ST_MUL: begin
        prod_q <= 64'(snap_q.count * snap_q.sq_sum);
        ssq_q  <= mag_q * mag_q;
        den_q  <= 32'(snap_q.count * (snap_q.count - 1'b1));
      end
      ST_SUB: begin
        drem_q <= {2'b00, num[61:32]};
        dsh_q  <= {num[31:0], 16'd0};
        mrem_q <= mag_q[31:16];
        msh_q  <= {mag_q[15:0], 8'd0};
      end
      ST_DIV: begin
        drem_q <= dge ? 32'(dtr - {1'b0, den_q}) : dtr[31:0];
        dsh_q  <= {dsh_q[46:0], 1'b0};
        dquo_q <= {dquo_q[46:0], dge};
        if (cnt_q >= 6'd24) begin
          mrem_q <= mge ? 16'(mtr - {1'b0, snap_q.count}) : mtr[15:0];
          msh_q  <= {msh_q[22:0], 1'b0};
          mquo_q <= {mquo_q[22:0], mge};
        end
        if (cnt_q == 6'd0) begin
          sv_q    <= {dquo_q[46:0], dge};
          srem_q  <= '0;
          sroot_q <= '0;
        end
      end
      ST_SQRT: begin
        srem_q  <= sge ? 25'(str - strial) : str[24:0];
        sroot_q <= {sroot_q[22:0], sge};
        sv_q    <= {sv_q[45:0], 2'b00};
      end
      default: ;
    endcase
    if (st_q == ST_DONE && out_free) begin
      o_cnt_q  <= snap_q.count;
      o_mean_q <= neg_q ? -mean_t'(mquo_q) : mean_t'(mquo_q);
      o_sd_q   <= (snap_q.count < 16'd2) ? '0 : sroot_q;
      o_lo_q   <= snap_q.lo;
      o_hi_q   <= snap_q.hi;
      o_sat_q  <= snap_q.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (st_q == ST_DONE && out_free) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: if (valid_i) st_q <= ST_MUL;
        ST_MUL:  st_q <= ST_SUB;
        ST_SUB: begin
          st_q  <= ST_DIV;
          cnt_q <= 6'd47;
        end
        ST_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 6'd0) begin
            st_q  <= ST_SQRT;
            cnt_q <= 6'd23;
          end
        end
        ST_SQRT: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 6'd0) st_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.sample_count = o_cnt_q;
  assign out_o.mean_q8      = o_mean_q;
  assign out_o.stdev_q8     = o_sd_q;
  assign out_o.lowest       = o_lo_q;
  assign out_o.highest      = o_hi_q;
  assign out_o.saturated    = o_sat_q;

endmodule

// File: hw/rtl/rmsm_checker.sv
// ----------------------------------------------------------------------------
// rmsm_props
// Port-level checks of the running statistics unit.
// ----------------------------------------------------------------------------
module rmsm_props (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid,
  input logic                   out_ready,
  input rmsm_pkg::count_t       sample_count,
  input rmsm_pkg::stdev_t       stdev_q8,
  input rmsm_pkg::sample_t      lowest,
  input rmsm_pkg::sample_t      highest,
  input logic                   saturated
);
  import rmsm_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(sample_count) && $stable(stdev_q8))
    else $error("result changed while stalled");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && saturated |-> sample_count == COUNT_MAX)
    else $error("saturation below count limit");

  a_sd0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && sample_count < 16'd2 |-> stdev_q8 == '0)
    else $error("nonzero deviation with fewer than two samples");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> lowest <= highest)
    else $error("lowest above highest");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && sample_count == 16'd1 |-> lowest == highest)
    else $error("extremes differ after one sample");

endmodule

bind running_mean_stdev_minmax_unit rmsm_props u_rmsm_props (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .sample_count (out_o.sample_count),
  .stdev_q8     (out_o.stdev_q8),
  .lowest       (out_o.lowest),
  .highest      (out_o.highest),
  .saturated    (out_o.saturated)
);

// File: tb/sv/rmsm_checker.sv
// ----------------------------------------------------------------------------
// rmsm_checker
// Watches both channels of the running statistics unit and predicts each
// result from its own copy of the accumulators. It compares every output
// transaction with the oldest prediction and counts the mismatches.
// ----------------------------------------------------------------------------
module rmsm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmsm_in_if          in_mon,
  rmsm_out_if         out_mon,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rmsm_pkg::*;

  typedef struct packed {
    count_t  n;
    mean_t   mean;
    stdev_t  sd;
    sample_t lo;
    sample_t hi;
    logic    sat;
  } stats_t;

  longint unsigned acc_n;
  longint          acc_sum;
  longint unsigned acc_sq;
  sample_t         acc_lo;
  sample_t         acc_hi;
  stats_t          stats_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic stdev_t sample_stdev();
    longint unsigned mag, num, den, whole, frac, q, r;
    if (acc_n < 2) return '0;
    mag = (acc_sum < 0) ? longint'(-acc_sum) : longint'(acc_sum);
    num = acc_n * acc_sq;
    if (num < mag * mag) return '0;
    num = num - mag * mag;
    den = acc_n * (acc_n - 1);
    whole = num / den;
    frac = ((num % den) << 16) / den;
    if (whole > (64'd1 << 40)) return '1;
    q = (whole << 16) + frac;
    r = int_sqrt(q);
    return (r > 64'hFFFFFF) ? '1 : stdev_t'(r);
  endfunction

  function automatic stats_t accumulate(sample_t s, logic clr);
    stats_t  e;
    longint  d, m;
    d = longint'(s);
    if (clr) begin
      acc_n = 0; acc_sum = 0; acc_sq = 0; acc_lo = '0; acc_hi = '0;
    end
    e.sat = 1'b0;
    if (acc_n >= longint'(COUNT_MAX)) begin
      e.sat = 1'b1;
    end else begin
      acc_n++;
      acc_sum += d;
      acc_sq += longint'(d * d);
      if (acc_n == 1) begin
        acc_lo = s; acc_hi = s;
      end else if (s < acc_lo) begin
        acc_lo = s;
      end else if (s > acc_hi) begin
        acc_hi = s;
      end
    end
    m = 0;
    if (acc_n > 0) begin
      m = (acc_sum * 256) / longint'(acc_n);
      if (m > 64'sd8388607) m = 8388607;
      if (m < -64'sd8388608) m = -8388608;
    end
    e.n = count_t'(acc_n);
    e.mean = mean_t'(m);
    e.sd = sample_stdev();
    e.lo = acc_lo;
    e.hi = acc_hi;
    return e;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t checker: %s got %0h expected %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stats_t e;
    if (!rst_ni) begin
      acc_n = 0; acc_sum = 0; acc_sq = 0; acc_lo = '0; acc_hi = '0;
      stats_q.delete();
      errors_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (stats_q.size() == 0) begin
          report("unexpected transaction, count", out_mon.sample_count, 0);
        end else begin
          e = stats_q.pop_front();
          if (out_mon.sample_count !== e.n) report("sample_count", out_mon.sample_count, e.n);
          if (out_mon.mean_q8 !== e.mean) report("mean_q8", out_mon.mean_q8, e.mean);
          if (out_mon.stdev_q8 !== e.sd) report("stdev_q8", out_mon.stdev_q8, e.sd);
          if (out_mon.lowest !== e.lo) report("lowest", out_mon.lowest, e.lo);
          if (out_mon.highest !== e.hi) report("highest", out_mon.highest, e.hi);
          if (out_mon.saturated !== e.sat) report("saturated", out_mon.saturated, e.sat);
        end
      end
      if (in_mon.valid && in_mon.ready)
        stats_q.push_back(accumulate(in_mon.sample, in_mon.clear_first));
    end
    pending_o = stats_q.size();
  end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives samples into the running statistics unit under several idle and
// stall mixes: directed extremes first, then random runs between clears.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmsm_pkg::*;

  localparam int WATCHDOG_CYCLES = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors;
  int   pending;
  int   send_idle = 0;
  int   recv_stall = 0;
  int   idle_cnt = 0;
  int   sent = 0;
  int   clears = 0;

  rmsm_in_if  in_if ();
  rmsm_out_if out_if ();

  running_mean_stdev_minmax_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  rmsm_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.sample = '0;
    in_if.clear_first = 1'b0;
    out_if.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    out_if.ready = ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_CYCLES) begin
      $display("tb: watchdog expired");
      $display("tb: errors");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send(sample_t s, logic clr);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.sample = s;
    in_if.clear_first = clr;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
    if (clr) clears++;
    @(negedge clk_i);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(5))
      0: return sample_t'($urandom_range(65535));
      1: return sample_t'($signed($urandom_range(64)) - 32);
      2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      3: return sample_t'(32767 - $urandom_range(300));
      4: return sample_t'(-32768 + $urandom_range(300));
      default: return sample_t'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  task automatic drain();
    in_if.valid = 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  initial begin
    int len;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: no clear from reset, extremes, single-sample clears
    send(16'sh7FFF, 1'b0);
    send(16'sh7FFF, 1'b0);
    send(16'sh8000, 1'b0);
    send(16'sh0000, 1'b0);
    send(16'sh8000, 1'b1);
    send(16'sh8000, 1'b0);
    send(16'sh8000, 1'b0);
    send(16'sh0001, 1'b1);
    send(-16'sh0001, 1'b1);
    send(16'sh0005, 1'b1);
    send(16'sh0005, 1'b0);
    send(16'sh0006, 1'b0);
    send(16'sh0004, 1'b0);
    send(16'sh7FFF, 1'b1);
    send(16'sh8000, 1'b0);
    send(16'sh7FFF, 1'b0);
    send(16'sh8000, 1'b0);
    send(16'sh5555, 1'b1);
    send(16'shAAAA, 1'b0);
    send(-16'sh0003, 1'b0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 46; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 46; end
        default: begin send_idle = 18; recv_stall = 18; end
      endcase
      for (int k = 0; k < 220; ) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(120, 60) : $urandom_range(30, 1);
        for (int j = 0; j < len && k < 220; j++, k++)
          send(pick_sample(), (j == 0) || ($urandom_range(49) == 0));
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("tb: %0d samples sent, %0d of them clearing the statistic", sent, clears);
    $display("tb: covered extremes, short runs and long runs under four idle mixes");
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
